/* hdl/abpg_pkg.sv */
// Shared types, command codes and constants for the alarm beep pattern generator.
package abpg_pkg;

    // Default values of the top level parameters
    localparam int SINE_ADDR_BITS_DEF = 10;
    localparam int PHASE_BITS_DEF     = 16;
    localparam int SAMPLE_RATE_DEF    = 16000;

    // Timing constants behind the register defaults
    localparam int TONE_MS       = 170;
    localparam int GAP_MS        = 130;
    localparam int BEEPS_DEFAULT = 3;
    localparam int CYCLE_MS      = 2000;
    localparam int BEEP_HZ       = 880;
    localparam int EDGE_MS       = 12;
    localparam int MS_PER_S      = 1000;

    // Full-scale envelope in Q1.16
    localparam logic [16:0] ENV_ONE = 17'd65536;

    // Odd polynomial for a quarter sine wave, Q16 coefficients
    localparam logic [17:0] POLY_A = 18'd102944;
    localparam logic [16:0] POLY_B = 17'd42334;
    localparam logic [12:0] POLY_C = 13'd5223;

    // Largest output magnitude
    localparam logic [14:0] MAG_MAX = 15'h7fff;

    // Shared radix-4 multiplier geometry
    localparam int MUL_A_W    = 31;
    localparam int MUL_B_W    = 18;
    localparam int MUL_DIGITS = MUL_B_W / 2;
    localparam int DIGIT_W    = $clog2(MUL_DIGITS);

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] CFG_TONE_LEN   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_LEN    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_LEN   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENV_STEP   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CYCLE_LEN  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_BEEP_COUNT = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_STEP = 3'd6;

    // Command codes of an input request
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    typedef struct packed {
        logic [1:0]          cmd;
        logic signed [15:0]  amplitude;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0]  sample;
        logic                cycle_last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ENV,
        ST_LOAD,
        ST_MUL,
        ST_DONE
    } state_t;

    // Products computed in turn by the shared multiplier
    typedef enum logic [2:0] {
        OP_ENV,
        OP_SQUARE,
        OP_TERM_C,
        OP_TERM_B,
        OP_TERM_A,
        OP_AMP,
        OP_SCALE
    } op_t;

endpackage

/* hdl/alarm_beep_pattern_generator.sv */
// Alarm beep pattern generator: pattern sequencer, envelope and serial sine datapath.
// A tick inside a tone passes the prepare and envelope states and seven load and multiply
// steps before its result enters the output register; one outside a tone skips the multiplies.
// Start and stop requests give no result. No new request is taken until the sample is in
// the output register; the shared radix-4 multiplier runs seven products of nine digits.
// Reset: aresetn is synchronous and active low; playback stops, positions clear and the
// configuration registers take their defaults derived from SAMPLE_RATE.
module alarm_beep_pattern_generator #(
    parameter int SINE_ADDR_BITS = abpg_pkg::SINE_ADDR_BITS_DEF,
    parameter int PHASE_BITS     = abpg_pkg::PHASE_BITS_DEF,
    parameter int SAMPLE_RATE    = abpg_pkg::SAMPLE_RATE_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  abpg_pkg::in_item_t                   s_item,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output abpg_pkg::out_item_t                  m_item,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [abpg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [abpg_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import abpg_pkg::*;

    // Register defaults follow the sample rate
    localparam int    TONE_RST   = SAMPLE_RATE * TONE_MS / MS_PER_S;
    localparam int    GAP_RST    = SAMPLE_RATE * GAP_MS / MS_PER_S;
    localparam int    EDGE_RST   = (SAMPLE_RATE * EDGE_MS / MS_PER_S) % 32768;
    localparam int    ENV_RST    = (EDGE_RST != 0) ? (65536 / EDGE_RST) % 131072 : 65536;
    localparam int    CYCLE_RST  = SAMPLE_RATE * CYCLE_MS / MS_PER_S;
    localparam longint PSTEP_RST = (longint'(BEEP_HZ) << PHASE_BITS) / SAMPLE_RATE;
    localparam int    SUM_W      = ((PHASE_BITS > 15) ? PHASE_BITS : 15) + 1;
    localparam int    X_SHIFT    = 18 - SINE_ADDR_BITS;
    localparam logic [DIGIT_W-1:0] DIGIT_LAST = DIGIT_W'(MUL_DIGITS - 1);

    // Configuration registers
    logic [15:0] tone_len_reg;
    logic [15:0] gap_len_reg;
    logic [14:0] edge_len_reg;
    logic [16:0] env_step_reg;
    logic [16:0] cycle_len_reg;
    logic [3:0]  beep_count_reg;
    logic [14:0] phase_step_reg;

    // Playback state
    logic                   playing_reg;
    logic signed [15:0]     peak_amp_reg;
    logic [16:0]            cycle_pos_reg;
    logic [16:0]            unit_pos_reg;
    logic [3:0]             beep_idx_reg;
    logic [PHASE_BITS-1:0]  phase_reg;

    // Per-sample operands
    logic        active_reg;
    logic        last_reg;
    logic [15:0] i_reg;
    logic [15:0] edge_reg;
    logic [16:0] x_reg;
    logic [1:0]  quad_reg;
    logic [15:0] m_reg;
    logic        env_full_reg;
    logic [15:0] ma_reg;
    logic        neg_reg;
    logic [16:0] t2_reg;
    logic [16:0] env_reg;

    // Shared multiplier
    logic [MUL_A_W-1:0]   a_reg;
    logic [MUL_A_W+1:0]   a3_reg;
    logic [MUL_B_W-1:0]   b_reg;
    logic [MUL_A_W-1:0]   hi_reg;
    logic [MUL_B_W-1:0]   lo_reg;
    logic [DIGIT_W-1:0]   digit_cnt_reg;
    op_t                  op_reg;
    op_t                  op_next;

    // Control
    state_t    state_reg;
    state_t    state_next;
    logic      m_valid_reg;
    out_item_t m_item_reg;
    logic      out_load;

    // Combinational helpers
    logic                              in_accept;
    logic [16:0]                       clen;
    logic [17:0]                       cyc_inc;
    logic                              last_now;
    logic                              beep_on;
    logic [17:0]                       unit_inc;
    logic [17:0]                       unit_bound;
    logic [SUM_W-1:0]                  phase_sum;
    logic [SINE_ADDR_BITS-1:0]         sine_addr;
    logic [16:0]                       x_raw;
    logic [15:0]                       half_tone;
    logic [15:0]                       rel_point;
    logic [MUL_A_W+MUL_B_W-1:0]        prod;
    logic [16:0]                       env_val;
    logic [16:0]                       t2_val;
    logic [15:0]                       inner_val;
    logic [16:0]                       outer_val;
    logic [14:0]                       ms_val;
    logic [29:0]                       msma_val;
    logic [14:0]                       mag_val;
    logic signed [15:0]                sample_val;
    logic [MUL_A_W-1:0]                a_load;
    logic [MUL_B_W-1:0]                b_load;
    logic [MUL_A_W+1:0]                addend;
    logic [MUL_A_W+1:0]                mul_sum;

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;
    assign in_accept = s_valid && s_ready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tone_len_reg   <= 16'(TONE_RST);
            gap_len_reg    <= 16'(GAP_RST);
            edge_len_reg   <= 15'(EDGE_RST);
            env_step_reg   <= 17'(ENV_RST);
            cycle_len_reg  <= 17'(CYCLE_RST);
            beep_count_reg <= 4'(BEEPS_DEFAULT);
            phase_step_reg <= 15'(PSTEP_RST);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TONE_LEN:   tone_len_reg   <= cfg_data[15:0];
                CFG_GAP_LEN:    gap_len_reg    <= cfg_data[15:0];
                CFG_EDGE_LEN:   edge_len_reg   <= cfg_data[14:0];
                CFG_ENV_STEP:   env_step_reg   <= cfg_data;
                CFG_CYCLE_LEN:  cycle_len_reg  <= cfg_data;
                CFG_BEEP_COUNT: beep_count_reg <= cfg_data[3:0];
                CFG_PHASE_STEP: phase_step_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Pattern position arithmetic for the current tick
    always_comb begin
        clen       = (cycle_len_reg == 17'd0) ? 17'd1 : cycle_len_reg;
        cyc_inc    = 18'(cycle_pos_reg) + 18'd1;
        last_now   = (cyc_inc >= 18'(clen));
        beep_on    = (beep_idx_reg < beep_count_reg);
        unit_inc   = 18'(unit_pos_reg) + 18'd1;
        unit_bound = 18'(tone_len_reg) + 18'(gap_len_reg);
        phase_sum  = SUM_W'(phase_reg) + SUM_W'(phase_step_reg);
        sine_addr  = phase_reg[PHASE_BITS-1 -: SINE_ADDR_BITS];
        x_raw      = 17'(sine_addr[SINE_ADDR_BITS-3:0]) << X_SHIFT;
        half_tone  = {1'b0, tone_len_reg[15:1]};
        rel_point  = tone_len_reg - edge_reg;
    end

    // Values taken from the finished product, one per multiply step
    always_comb begin
        prod      = {hi_reg, lo_reg};
        if (env_full_reg || (|prod[48:17]) || (prod[16] && (|prod[15:0]))) begin
            env_val = ENV_ONE;
        end else begin
            env_val = prod[16:0];
        end
        t2_val    = prod[32:16];
        inner_val = 16'(POLY_B - 17'(prod[31:16]));
        outer_val = 17'(POLY_A - 18'(prod[31:16]));
        ms_val    = (|prod[33:32]) ? MAG_MAX : prod[31:17];
        msma_val  = prod[29:0];
        mag_val   = (|prod[48:46]) ? MAG_MAX : prod[45:31];
        if (!active_reg) begin
            sample_val = 16'sd0;
        end else if (neg_reg) begin
            sample_val = 16'(16'd0 - {1'b0, mag_val});
        end else begin
            sample_val = 16'({1'b0, mag_val});
        end
    end

    // Operand selection for the next multiply
    always_comb begin
        unique case (op_reg)
            OP_ENV: begin
                a_load = MUL_A_W'(env_step_reg);
                b_load = MUL_B_W'(m_reg);
            end
            OP_SQUARE: begin
                a_load = MUL_A_W'(x_reg);
                b_load = MUL_B_W'(x_reg);
            end
            OP_TERM_C: begin
                a_load = MUL_A_W'(POLY_C);
                b_load = MUL_B_W'(t2_val);
            end
            OP_TERM_B: begin
                a_load = MUL_A_W'(inner_val);
                b_load = MUL_B_W'(t2_reg);
            end
            OP_TERM_A: begin
                a_load = MUL_A_W'(outer_val);
                b_load = MUL_B_W'(x_reg);
            end
            OP_AMP: begin
                a_load = MUL_A_W'(ms_val);
                b_load = MUL_B_W'(ma_reg);
            end
            OP_SCALE: begin
                a_load = MUL_A_W'(msma_val);
                b_load = MUL_B_W'(env_reg);
            end
            default: begin
                a_load = '0;
                b_load = '0;
            end
        endcase
    end

    // Step order of the multiply sequence
    always_comb begin
        unique case (op_reg)
            OP_ENV:    op_next = OP_SQUARE;
            OP_SQUARE: op_next = OP_TERM_C;
            OP_TERM_C: op_next = OP_TERM_B;
            OP_TERM_B: op_next = OP_TERM_A;
            OP_TERM_A: op_next = OP_AMP;
            OP_AMP:    op_next = OP_SCALE;
            default:   op_next = OP_ENV;
        endcase
    end

    // One radix-4 digit of the multiplier per cycle
    always_comb begin
        unique case (b_reg[1:0])
            2'd0:    addend = '0;
            2'd1:    addend = (MUL_A_W+2)'(a_reg);
            2'd2:    addend = (MUL_A_W+2)'({a_reg, 1'b0});
            default: addend = a3_reg;
        endcase
        mul_sum = (MUL_A_W+2)'(hi_reg) + addend;
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and handshake outputs
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && (s_item.cmd == CMD_TICK) && playing_reg) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: state_next = ST_ENV;
            ST_ENV:  state_next = active_reg ? ST_LOAD : ST_DONE;
            ST_LOAD: state_next = ST_MUL;
            ST_MUL: begin
                if (digit_cnt_reg == DIGIT_LAST) begin
                    state_next = (op_reg == OP_SCALE) ? ST_DONE : ST_LOAD;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Playback state: commands, then the position update of each tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            playing_reg   <= 1'b0;
            peak_amp_reg  <= '0;
            cycle_pos_reg <= '0;
            unit_pos_reg  <= '0;
            beep_idx_reg  <= '0;
            phase_reg     <= '0;
        end else if (in_accept && (s_item.cmd == CMD_START)) begin
            if (!playing_reg) begin
                playing_reg   <= 1'b1;
                cycle_pos_reg <= '0;
                unit_pos_reg  <= '0;
                beep_idx_reg  <= '0;
                phase_reg     <= '0;
            end
            peak_amp_reg <= s_item.amplitude;
        end else if (in_accept && (s_item.cmd == CMD_STOP)) begin
            playing_reg <= 1'b0;
        end else if (state_reg == ST_PREP) begin
            if (last_now) begin
                cycle_pos_reg <= '0;
                unit_pos_reg  <= '0;
                beep_idx_reg  <= '0;
                phase_reg     <= '0;
            end else begin
                cycle_pos_reg <= cyc_inc[16:0];
                if (beep_on) begin
                    if (unit_inc >= unit_bound) begin
                        unit_pos_reg <= '0;
                        beep_idx_reg <= beep_idx_reg + 4'd1;
                        phase_reg    <= '0;
                    end else begin
                        unit_pos_reg <= unit_inc[16:0];
                        phase_reg    <= phase_sum[PHASE_BITS-1:0];
                    end
                end
            end
        end
    end

    // Sample operands and the serial multiplier
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_PREP: begin
                // Capture the sample's position before the state moves on
                active_reg <= beep_on && (unit_pos_reg < 17'(tone_len_reg));
                last_reg   <= last_now;
                i_reg      <= unit_pos_reg[15:0];
                edge_reg   <= (16'(edge_len_reg) > half_tone) ? half_tone : 16'(edge_len_reg);
                quad_reg   <= sine_addr[SINE_ADDR_BITS-1 -: 2];
                x_reg      <= sine_addr[SINE_ADDR_BITS-2] ? ENV_ONE - x_raw : x_raw;
            end
            ST_ENV: begin
                // Attack ramp, release ramp or full level
                if (i_reg < edge_reg) begin
                    m_reg        <= i_reg;
                    env_full_reg <= 1'b0;
                end else if (i_reg > rel_point) begin
                    m_reg        <= tone_len_reg - i_reg;
                    env_full_reg <= 1'b0;
                end else begin
                    m_reg        <= '0;
                    env_full_reg <= 1'b1;
                end
                ma_reg  <= peak_amp_reg[15] ? 16'd0 - peak_amp_reg : peak_amp_reg;
                neg_reg <= quad_reg[1] ^ peak_amp_reg[15];
                op_reg  <= OP_ENV;
            end
            ST_LOAD: begin
                if (op_reg == OP_SQUARE) begin
                    env_reg <= env_val;
                end
                if (op_reg == OP_TERM_C) begin
                    t2_reg <= t2_val;
                end
                a_reg         <= a_load;
                a3_reg        <= (MUL_A_W+2)'(a_load) + (MUL_A_W+2)'({a_load, 1'b0});
                b_reg         <= b_load;
                hi_reg        <= '0;
                lo_reg        <= '0;
                digit_cnt_reg <= '0;
            end
            ST_MUL: begin
                hi_reg        <= mul_sum[MUL_A_W+1:2];
                lo_reg        <= {mul_sum[1:0], lo_reg[MUL_B_W-1:2]};
                b_reg         <= {2'b00, b_reg[MUL_B_W-1:2]};
                digit_cnt_reg <= digit_cnt_reg + DIGIT_W'(1);
                if (digit_cnt_reg == DIGIT_LAST) begin
                    op_reg <= op_next;
                end
            end
            default: ;
        endcase
    end

    // Output register decouples the result from the next request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_item_reg.sample     <= sample_val;
            m_item_reg.cycle_last <= last_reg;
        end
    end

endmodule

/* bench/tb.sv */
// Self-checking testbench for the alarm beep pattern generator with its own sample predictor.
`timescale 1ns / 100ps

module tb;
    import abpg_pkg::*;

    localparam int SAB          = SINE_ADDR_BITS_DEF;
    localparam int PB           = PHASE_BITS_DEF;
    localparam int RATE         = SAMPLE_RATE_DEF;
    localparam longint unsigned PHASE_MASK = (64'd1 << PB) - 64'd1;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_NONE = 3'd7;
    localparam int IDLE_PCT     = 7;
    localparam int DRAIN_CYCLES = 100;
    localparam int ITEM_TOTAL   = 1650;
    localparam int STALL_CYCLES = 3000;

    // Clock and synchronous reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #10 aclk = ~aclk;

    // Block ports; the inputs are known from time zero
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_item    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_item;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    alarm_beep_pattern_generator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Request and sample queues, error count and idling control
    in_item_t    pending_cmds[$];
    out_item_t   expected_samples[$];
    int          err_count  = 0;
    int          queued     = 0;
    int          rx_count   = 0;
    int          idle_pct   = IDLE_PCT;
    int          stall_left = 0;
    bit          stall_done = 1'b0;

    // Predicted register values, starting at the reset defaults
    int unsigned cfg_tone   = RATE * TONE_MS / MS_PER_S;
    int unsigned cfg_gap    = RATE * GAP_MS / MS_PER_S;
    int unsigned cfg_edge   = RATE * EDGE_MS / MS_PER_S;
    int unsigned cfg_step   = 65536 / (RATE * EDGE_MS / MS_PER_S);
    int unsigned cfg_cycle  = RATE * CYCLE_MS / MS_PER_S;
    int unsigned cfg_beeps  = BEEPS_DEFAULT;
    int unsigned cfg_pstep  = (longint'(BEEP_HZ) << PB) / RATE;

    // Predicted playback state
    bit                 play_on  = 1'b0;
    logic signed [15:0] amp_peak = '0;
    int unsigned        cyc_pos  = 0;
    int unsigned        unit_pos = 0;
    int unsigned        beep_idx = 0;
    int unsigned        ph       = 0;

    // Quarter-wave polynomial sine in Q1.15, mirrored and negated by quadrant.
    function automatic int sine_at(input int unsigned p);
        longint unsigned addr, quad, q, x, t2, inner, outer, y;
        addr  = (longint'(p) & PHASE_MASK) >> (PB - SAB);
        quad  = (addr >> (SAB - 2)) & 64'd3;
        q     = addr & ((64'd1 << (SAB - 2)) - 64'd1);
        x     = q << (18 - SAB);
        if ((quad & 64'd1) != 0) x = 64'd65536 - x;
        t2    = (x * x) >> 16;
        inner = 64'(POLY_B) - ((64'(POLY_C) * t2) >> 16);
        outer = 64'(POLY_A) - ((inner * t2) >> 16);
        y     = (outer * x) >> 17;
        if (y > 64'd32767) y = 64'd32767;
        return ((quad & 64'd2) != 0) ? -int'(y) : int'(y);
    endfunction

    // Enveloped tone sample at position i of the current beep.
    function automatic int tone_level(input int unsigned i);
        int unsigned     ramp;
        longint unsigned env, ms, ma, mag;
        int              s, a;
        bit              neg;
        ramp = cfg_edge;
        if (ramp > cfg_tone / 2) ramp = cfg_tone / 2;
        if (i < ramp) env = 64'(i) * 64'(cfg_step);
        else if (i > cfg_tone - ramp) env = 64'(cfg_tone - i) * 64'(cfg_step);
        else env = 64'(ENV_ONE);
        if (env > 64'(ENV_ONE)) env = 64'(ENV_ONE);
        s   = sine_at(ph);
        a   = amp_peak;
        neg = (s < 0) != (a < 0);
        ms  = (s < 0) ? 64'(-s) : 64'(s);
        ma  = (a < 0) ? 64'(-a) : 64'(a);
        mag = (ms * ma * env) >> 31;
        if (mag > 64'd32767) mag = 64'd32767;
        return neg ? -int'(mag) : int'(mag);
    endfunction

    // Advances the predicted state by one request; returns 1 when a sample is due.
    function automatic bit beep_predict(input in_item_t it, output out_item_t res);
        int unsigned clen;
        int          smp;
        bit          last;
        res = '0;
        case (it.cmd)
            CMD_START: begin
                if (!play_on) begin
                    play_on  = 1'b1;
                    cyc_pos  = 0;
                    unit_pos = 0;
                    beep_idx = 0;
                    ph       = 0;
                end
                amp_peak = it.amplitude;
                return 1'b0;
            end
            CMD_STOP: begin
                play_on = 1'b0;
                return 1'b0;
            end
            CMD_TICK: ;
            default: return 1'b0;
        endcase
        if (!play_on) return 1'b0;

        clen = (cfg_cycle != 0) ? cfg_cycle : 1;
        smp  = 0;
        if (beep_idx < cfg_beeps && unit_pos < cfg_tone) smp = tone_level(unit_pos);
        last = (cyc_pos + 1 >= clen);
        res.sample     = 16'(smp);
        res.cycle_last = last;

        // Step the cycle, unit and phase counters; positions past a bound wrap.
        if (last) begin
            cyc_pos  = 0;
            unit_pos = 0;
            beep_idx = 0;
            ph       = 0;
        end else begin
            cyc_pos++;
            if (beep_idx < cfg_beeps) begin
                unit_pos++;
                ph = int'((64'(ph) + 64'(cfg_pstep)) & PHASE_MASK);
                if (unit_pos >= cfg_tone + cfg_gap) begin
                    unit_pos = 0;
                    beep_idx = (beep_idx + 1) & 15;
                    ph       = 0;
                end
            end
        end
        return 1'b1;
    endfunction

    // Driver: presents queued requests and predicts each accepted one.
    always @(posedge aclk) begin : driver
        out_item_t res;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (beep_predict(s_item, res)) expected_samples.push_back(res);
            end
            if (!s_valid || s_ready) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    s_valid <= 1'b1;
                    s_item  <= pending_cmds.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted sample and throttles the result channel.
    always @(posedge aclk) begin : monitor
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    $error("unexpected result: sample %0d cycle_last %0b",
                           m_item.sample, m_item.cycle_last);
                    err_count++;
                end else begin
                    want = expected_samples.pop_front();
                    if (m_item.sample !== want.sample) begin
                        $error("sample mismatch: expected %0d, actual %0d",
                               want.sample, m_item.sample);
                        err_count++;
                    end
                    if (m_item.cycle_last !== want.cycle_last) begin
                        $error("cycle_last mismatch: expected %0b, actual %0b",
                               want.cycle_last, m_item.cycle_last);
                        err_count++;
                    end
                end
                rx_count++;
            end
            // One long hold-off while plenty of requests are still waiting.
            if (!stall_done && rx_count >= 200 && pending_cmds.size() > 60) begin
                stall_done <= 1'b1;
                stall_left <= STALL_CYCLES;
                m_ready    <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_ready    <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    function automatic void push_cmd(input logic [1:0] c, input logic [15:0] a);
        in_item_t it;
        it.cmd       = c;
        it.amplitude = a;
        pending_cmds.push_back(it);
        queued++;
    endfunction

    function automatic logic [15:0] rand_amp();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // A start, then mostly ticks with occasional restarts, stops and unused codes.
    task automatic queue_run(input int n, input bit end_stopped);
        int r;
        push_cmd(CMD_START, rand_amp());
        for (int k = 1; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 88) begin
                push_cmd(CMD_TICK, 16'($urandom_range(65535)));
            end else if (r < 92) begin
                push_cmd(CMD_START, rand_amp());
            end else if (r < 95) begin
                push_cmd(CMD_UNUSED, 16'($urandom_range(65535)));
            end else begin
                push_cmd(CMD_STOP, 16'($urandom_range(65535)));
                push_cmd(CMD_TICK, 16'($urandom_range(65535)));
                push_cmd(CMD_START, rand_amp());
            end
        end
        if (end_stopped) push_cmd(CMD_STOP, 16'h0000);
    endtask

    // Waits until every request is in and every sample is out, then lets the block settle.
    task automatic wait_drain();
        while (pending_cmds.size() != 0 || s_valid || expected_samples.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TONE_LEN:   cfg_tone  = val[15:0];
            CFG_GAP_LEN:    cfg_gap   = val[15:0];
            CFG_EDGE_LEN:   cfg_edge  = val[14:0];
            CFG_ENV_STEP:   cfg_step  = val[16:0];
            CFG_CYCLE_LEN:  cfg_cycle = val[16:0];
            CFG_BEEP_COUNT: cfg_beeps = val[3:0];
            CFG_PHASE_STEP: cfg_pstep = val[14:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [16:0] tone, input logic [16:0] gap,
                              input logic [16:0] ramp, input logic [16:0] step,
                              input logic [16:0] cyc, input logic [16:0] beeps,
                              input logic [16:0] pstep);
        write_reg(CFG_TONE_LEN, tone);
        write_reg(CFG_GAP_LEN, gap);
        write_reg(CFG_EDGE_LEN, ramp);
        write_reg(CFG_ENV_STEP, step);
        write_reg(CFG_CYCLE_LEN, cyc);
        write_reg(CFG_BEEP_COUNT, beeps);
        write_reg(CFG_PHASE_STEP, pstep);
    endtask

    // Mostly short patterns, now and then huge ones; unused upper data bits are random.
    task automatic random_config();
        int unsigned tone, gap, ramp, step, cyc, beeps, pstep;
        tone  = ($urandom_range(9) == 0) ? $urandom_range(65535, 1) : $urandom_range(60, 1);
        gap   = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(40);
        ramp  = ($urandom_range(7) == 0) ? 32767 : $urandom_range(30);
        if ($urandom_range(1) == 1) step = (ramp != 0) ? 65536 / ramp : 65536;
        else step = $urandom_range(65536);
        case ($urandom_range(19))
            0:       cyc = 0;
            1:       cyc = 131071;
            2:       cyc = $urandom_range(131071);
            default: cyc = $urandom_range(400, 1);
        endcase
        beeps = $urandom_range(15);
        pstep = $urandom_range(32767);
        set_config(17'(tone) | 17'($urandom_range(1) << 16),
                   17'(gap) | 17'($urandom_range(1) << 16),
                   17'(ramp) | 17'($urandom_range(3) << 15),
                   17'(step),
                   17'(cyc),
                   17'(beeps) | 17'($urandom_range(8191) << 4),
                   17'(pstep) | 17'($urandom_range(3) << 15));
    endtask

    // Stimulus sequence
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset defaults: idle commands, extreme amplitudes, restart while playing.
        push_cmd(CMD_TICK, 16'h1234);
        push_cmd(CMD_STOP, 16'h0000);
        push_cmd(CMD_UNUSED, 16'hffff);
        push_cmd(CMD_START, 16'h8000);
        repeat (4) push_cmd(CMD_TICK, 16'h0000);
        push_cmd(CMD_START, 16'h7fff);
        repeat (3) push_cmd(CMD_TICK, 16'hffff);
        push_cmd(CMD_UNUSED, 16'h5555);
        push_cmd(CMD_TICK, 16'haaaa);
        push_cmd(CMD_STOP, 16'h0000);
        push_cmd(CMD_TICK, 16'h0000);
        push_cmd(CMD_START, 16'h0000);
        repeat (2) push_cmd(CMD_TICK, 16'h0000);
        push_cmd(CMD_STOP, 16'h0000);
        push_cmd(CMD_START, 16'h0001);
        repeat (3) push_cmd(CMD_TICK, 16'h0000);
        push_cmd(CMD_STOP, 16'h0000);
        wait_drain();

        // Short beeps with a ramp, several cycles.
        set_config(17'd8, 17'd4, 17'd3, 17'd21845, 17'd40, 17'd3, 17'd3604);
        queue_run(200, 1'b1);
        wait_drain();

        // Shortest tone, ramp clamped away, zero cycle length, most beeps.
        set_config(17'd1, 17'd0, 17'd32767, 17'd65536, 17'd0, 17'd15, 17'd0);
        write_reg(CFG_NONE, 17'($urandom_range(131071)));
        queue_run(15, 1'b0);
        wait_drain();

        // Longest tone and gap, no ramp, fastest phase, with no idling on either side.
        idle_pct = 0;
        set_config(17'd65535, 17'd65535, 17'd0, 17'd0, 17'd131071, 17'd1, 17'd32767);
        queue_run(50, 1'b1);
        wait_drain();
        idle_pct = IDLE_PCT;

        // Ramp longer than half the tone, step matched to the clamped ramp.
        set_config(17'd20, 17'd5, 17'd32767, 17'd6553, 17'd60, 17'd2, 17'd1000);
        queue_run(70, 1'b0);
        wait_drain();

        // No beeps at all: silence only.
        set_config(17'd20, 17'd5, 17'd4, 17'd16384, 17'd10, 17'd0, 17'd500);
        queue_run(30, 1'b1);
        wait_drain();

        // Pattern longer than the cycle, cut off at the cycle end.
        set_config(17'd30, 17'd10, 17'd6, 17'd10922, 17'd100, 17'd5, 17'd2000);
        queue_run(250, 1'b0);
        wait_drain();

        // Random settings, some changed while playback is still on.
        while (queued < ITEM_TOTAL) begin
            random_config();
            queue_run($urandom_range(150, 40), 1'($urandom_range(1)));
            wait_drain();
        end

        if (err_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    // Run limit
    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
hdl/abpg_pkg.sv
hdl/alarm_beep_pattern_generator.sv
bench/tb.sv
